/* design/tws_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants for the three-wire serial master.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned TX_BITS   = 2 * BYTE_BITS;
	localparam int unsigned CNT_W     = $clog2(TX_BITS + 1);

	typedef logic [BYTE_BITS-1:0] byte_t;
	typedef logic [TX_BITS-1:0]   txw_t;
	typedef logic [CNT_W-1:0]     bitcnt_t;
	typedef logic [7:0]           tick_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SETUP = 3'd1,
		PH_LOW   = 3'd2,
		PH_HIGH  = 3'd3
	} phase_t;

	typedef struct packed {
		logic [1:0] command;
		byte_t      address;
		byte_t      write_data;
		logic       sio_in;
	} item_t;

	typedef struct packed {
		phase_t  phase;
		bitcnt_t bit_count;
		txw_t    tx_shift;
		byte_t   rx_shift;
		tick_t   tick_count;
		logic    is_read;
		logic    clock_level;
	} state_t;

	typedef struct packed {
		logic  sck;
		logic  ce;
		logic  sio_out;
		logic  sio_drive;
		logic  busy_res;
		logic  done_res;
		byte_t read_data;
		logic  rejected;
	} result_t;

endpackage
`default_nettype wire

/* design/tws_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tws_if
// Valid/ready channels of the three-wire serial master: request, result and
// configuration write.
// ----------------------------------------------------------------------------
interface tws_req_if
	import tws_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [1:0] command;
	byte_t      address;
	byte_t      write_data;
	logic       sio_in;

	modport source (output valid, command, address, write_data, sio_in, input ready);
	modport sink   (input valid, command, address, write_data, sio_in, output ready);
endinterface

interface tws_rsp_if
	import tws_pkg::*;
();
	logic  valid;
	logic  ready;
	logic  sck;
	logic  ce;
	logic  sio_out;
	logic  sio_drive;
	logic  busy_res;
	logic  done_res;
	byte_t read_data;
	logic  rejected;

	modport source (output valid, sck, ce, sio_out, sio_drive, busy_res, done_res,
		read_data, rejected, input ready);
	modport sink   (input valid, sck, ce, sio_out, sio_drive, busy_res, done_res,
		read_data, rejected, output ready);
endinterface

interface tws_cfg_if
	import tws_pkg::*;
();
	logic  valid;
	logic  ready;
	tick_t data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* design/tws_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tws_step
// One timebase tick of the link sequencer: next state and line levels.
// ----------------------------------------------------------------------------
module tws_step
	import tws_pkg::*;
(
	input  wire item_t   item,
	input  wire state_t  cur,
	input  wire tick_t   half_period,
	output state_t       nxt,
	output result_t      res
);

	tick_t   limit;
	tick_t   tick_inc;
	bitcnt_t bit_inc;
	logic    start;
	logic    rx_now;
	logic    rx_nxt;
	logic    done;
	logic    rej;

	assign limit    = (half_period == '0) ? tick_t'(1) : half_period;
	assign tick_inc = cur.tick_count + tick_t'(1);
	assign bit_inc  = cur.bit_count + bitcnt_t'(1);
	assign start    = (item.command == CMD_WRITE) || (item.command == CMD_READ);
	assign rx_now   = cur.is_read && (cur.bit_count >= bitcnt_t'(BYTE_BITS));
	assign rx_nxt   = nxt.is_read && (nxt.bit_count >= bitcnt_t'(BYTE_BITS));

	// next state
	always_comb begin
		nxt  = cur;
		done = 1'b0;
		rej  = 1'b0;
		case (cur.phase)
			PH_IDLE: begin
				if (start) begin
					nxt.is_read     = (item.command == CMD_READ);
					nxt.tx_shift    = (item.command == CMD_READ) ? {byte_t'(0), item.address}
						: {item.write_data, item.address};
					nxt.rx_shift    = '0;
					nxt.bit_count   = '0;
					nxt.tick_count  = '0;
					nxt.clock_level = 1'b0;
					nxt.phase       = PH_SETUP;
				end
			end
			default: begin
				rej            = start;
				nxt.tick_count = tick_inc;
				if (tick_inc >= limit) begin
					nxt.tick_count = '0;
					case (cur.phase)
						PH_SETUP: begin
							nxt.phase       = PH_LOW;
							nxt.clock_level = 1'b0;
						end
						PH_LOW: begin
							if (rx_now)
								nxt.rx_shift = {item.sio_in, cur.rx_shift[BYTE_BITS-1:1]};
							nxt.phase       = PH_HIGH;
							nxt.clock_level = 1'b1;
						end
						default: begin
							nxt.tx_shift  = cur.tx_shift >> 1;
							nxt.bit_count = bit_inc;
							if (bit_inc >= bitcnt_t'(TX_BITS)) begin
								nxt.phase       = PH_IDLE;
								nxt.clock_level = 1'b1;
								done            = 1'b1;
							end else begin
								nxt.phase       = PH_LOW;
								nxt.clock_level = 1'b0;
							end
						end
					endcase
				end
			end
		endcase
	end

	// line levels after the tick
	always_comb begin
		res           = '0;
		res.sck       = nxt.clock_level;
		res.ce        = (nxt.phase != PH_IDLE);
		res.busy_res  = (nxt.phase != PH_IDLE);
		res.done_res  = done;
		res.rejected  = rej;
		res.read_data = (done && nxt.is_read) ? nxt.rx_shift : '0;
		if (((nxt.phase == PH_LOW) || (nxt.phase == PH_HIGH)) && !rx_nxt) begin
			res.sio_drive = 1'b1;
			res.sio_out   = nxt.tx_shift[0];
		end
	end

endmodule
`default_nettype wire

/* design/three_wire_serial_master.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// three_wire_serial_master
// Chip enable / serial clock / bidirectional data link master, LSB first.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one item per timebase tick. command 0 is a plain tick, 1 starts a
//          write (address byte then write_data), 2 starts a read (address
//          byte then one received byte). sio_in is the data line level.
//   rsp  : one item per request item, with the line levels after that tick
//          (sck, ce, sio_out, sio_drive), busy, the done pulse, read_data on
//          the done item of a read, and rejected for a start while busy.
//   cfg  : write of half_period_ticks (ticks per clock half period, 0 acts
//          as 1). Always ready; write only while the link is idle.
// Path: a request item goes through the input register, then the result
//   register, before it shows up on rsp.
// Throughput: one item per clock while rsp is not stalled. The sequencer step
//   is a single pass of logic between the input register and the result register.
// Reset: arst_n clears the sequencer to idle, clock low, no items held, and
//   half_period_ticks to 1.
// Stall: with rsp.ready low and the result register full, that register holds;
//   the input register still takes one more item, then req.ready drops until rsp drains.
// ----------------------------------------------------------------------------
module three_wire_serial_master
	import tws_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	tws_req_if.sink      req,
	tws_rsp_if.source    rsp,
	tws_cfg_if.sink      cfg
);

	// input register stage
	logic    valid_s1;
	item_t   item_s1;

	// sequencer state and configuration
	state_t  state_q;
	state_t  state_nxt;
	tick_t   half_period_q;

	// result register
	logic    rsp_valid_q;
	result_t res_q;
	result_t res_nxt;

	logic    advance;
	logic    step_en;

	// result register can take a new item when empty or being drained
	assign advance   = !rsp_valid_q || rsp.ready;
	assign step_en   = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= tick_t'(1);
		end else if (cfg.valid) begin
			half_period_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.command    <= req.command;
			item_s1.address    <= req.address;
			item_s1.write_data <= req.write_data;
			item_s1.sio_in     <= req.sio_in;
		end
	end

	// one tick of the sequencer per accepted item
	tws_step u_step (
		.item        (item_s1),
		.cur         (state_q),
		.half_period (half_period_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
		end else if (step_en) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res_nxt;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.sck       = res_q.sck;
	assign rsp.ce        = res_q.ce;
	assign rsp.sio_out   = res_q.sio_out;
	assign rsp.sio_drive = res_q.sio_drive;
	assign rsp.busy_res  = res_q.busy_res;
	assign rsp.done_res  = res_q.done_res;
	assign rsp.read_data = res_q.read_data;
	assign rsp.rejected  = res_q.rejected;

endmodule
`default_nettype wire
